>>> design/utf8d_pkg.sv
// Shared types and constants for the UTF-8 byte stream decoder.
// No dependencies; every other design file uses this package.
package utf8d_pkg;

  localparam int unsigned CpW = 21;

  localparam logic [CpW-1:0] REPLACEMENT_CP = 21'h00FFFD;

  typedef enum logic [2:0] {
    KIND_ASCII,
    KIND_CONT,
    KIND_LEAD2,
    KIND_LEAD3,
    KIND_LEAD4,
    KIND_BAD
  } kind_e;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           is_replacement;
    logic           last;
  } result_t;

  // Results of one byte: count (0..2) and up to two words in order.
  typedef struct packed {
    logic [1:0] n;
    result_t    res0;
    result_t    res1;
  } step_t;

  // Byte class from the top five bits.
  function automatic kind_e kind_of(input logic [4:0] top5);
    kind_e k;
    if (top5[4] == 1'b0) begin
      k = KIND_ASCII;
    end else if (top5[3] == 1'b0) begin
      k = KIND_CONT;
    end else if (top5[2] == 1'b0) begin
      k = KIND_LEAD2;
    end else if (top5[1] == 1'b0) begin
      k = KIND_LEAD3;
    end else if (top5[0] == 1'b0) begin
      k = KIND_LEAD4;
    end else begin
      k = KIND_BAD;
    end
    return k;
  endfunction

endpackage

>>> design/utf8d_if.sv
// Handshake channels of the UTF-8 decoder: raw bytes in, code points out.
// Depends on utf8d_pkg for the code point width.
interface utf8d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

interface utf8d_cp_if;
  logic                      valid;
  logic                      ready;
  logic [utf8d_pkg::CpW-1:0] code_point;
  logic                      is_replacement;
  logic                      last;

  modport source (output valid, output code_point, output is_replacement, output last,
                  input ready);
  modport sink (input valid, input code_point, input is_replacement, input last,
                output ready);
endinterface

>>> design/utf8d_step.sv
// Per-byte decode: classifies the byte, holds the partial code point and
// pending count, and forms up to two result words. Uses utf8d_pkg.
module utf8d_step (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       byte_i,
  input  logic             fire_i,
  output utf8d_pkg::step_t step_o
);

  utf8d_pkg::kind_e          kind;
  logic [utf8d_pkg::CpW-1:0] partial_q, partial_d;
  logic [1:0]                pending_q, pending_d;
  logic [utf8d_pkg::CpW-1:0] cont_bits;
  utf8d_pkg::result_t        ascii_res;

  assign kind = utf8d_pkg::kind_of(byte_i[7:3]);

  assign ascii_res = '{code_point: {14'd0, byte_i[6:0]}, is_replacement: 1'b0, last: 1'b1};

  always_comb begin
    pending_d = pending_q - 2'd1;
    case (pending_d)
      2'd0:    cont_bits = {15'd0, byte_i[5:0]};
      2'd1:    cont_bits = {9'd0, byte_i[5:0], 6'd0};
      2'd2:    cont_bits = {3'd0, byte_i[5:0], 12'd0};
      default: cont_bits = '0;
    endcase
    partial_d     = partial_q;
    step_o.n      = 2'd0;
    step_o.res0   = ascii_res;
    step_o.res1   = ascii_res;
    case (kind)
      utf8d_pkg::KIND_BAD: begin
        pending_d = pending_q;
      end
      utf8d_pkg::KIND_CONT: begin
        if (pending_q == 2'd0) begin
          pending_d = pending_q;
        end else begin
          partial_d = partial_q | cont_bits;
          if (pending_d == 2'd0) begin
            step_o.n    = 2'd1;
            step_o.res0 = '{code_point: partial_q | cont_bits, is_replacement: 1'b0,
                            last: 1'b1};
          end
        end
      end
      default: begin
        // ASCII or lead; an open sequence is closed with a replacement first.
        if (pending_q != 2'd0) begin
          step_o.res0 = '{code_point: utf8d_pkg::REPLACEMENT_CP, is_replacement: 1'b1,
                          last: (kind != utf8d_pkg::KIND_ASCII)};
        end
        case (kind)
          utf8d_pkg::KIND_ASCII: begin
            pending_d = 2'd0;
            step_o.n  = (pending_q != 2'd0) ? 2'd2 : 2'd1;
          end
          utf8d_pkg::KIND_LEAD2: begin
            pending_d = 2'd1;
            partial_d = {10'd0, byte_i[4:0], 6'd0};
            step_o.n  = (pending_q != 2'd0) ? 2'd1 : 2'd0;
          end
          utf8d_pkg::KIND_LEAD3: begin
            pending_d = 2'd2;
            partial_d = {5'd0, byte_i[3:0], 12'd0};
            step_o.n  = (pending_q != 2'd0) ? 2'd1 : 2'd0;
          end
          default: begin
            pending_d = 2'd3;
            partial_d = {byte_i[2:0], 18'd0};
            step_o.n  = (pending_q != 2'd0) ? 2'd1 : 2'd0;
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 2'd0;
      partial_q <= '0;
    end else if (fire_i) begin
      pending_q <= pending_d;
      partial_q <= partial_d;
    end
  end

`ifndef SYNTHESIS
  // Two words only come from ASCII closing an open sequence.
  a_two_needs_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_o.n == 2'd2 |-> pending_q != 2'd0 && kind == utf8d_pkg::KIND_ASCII)
    else $error("two results without an open sequence");

  // Invalid bytes leave the sequence state alone.
  a_bad_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && kind == utf8d_pkg::KIND_BAD |=> $stable(pending_q) && $stable(partial_q))
    else $error("invalid byte changed decoder state");

  // A finished code point leaves nothing pending.
  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && kind == utf8d_pkg::KIND_CONT && step_o.n == 2'd1 |=> pending_q == 2'd0)
    else $error("pending count not cleared after completion");
`endif

endmodule

>>> design/utf8d_result_fifo.sv
// Two-word result buffer: takes up to two words per cycle, gives one.
// Uses utf8d_pkg for the result word type.
module utf8d_result_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         push_n_i,
  input  utf8d_pkg::result_t res0_i,
  input  utf8d_pkg::result_t res1_i,
  output logic [1:0]         free_o,
  output logic               valid_o,
  input  logic               ready_i,
  output utf8d_pkg::result_t head_o
);

  utf8d_pkg::result_t ent_q [2];
  utf8d_pkg::result_t ent_d [2];
  logic [1:0]         count_q, count_d, cnt;
  logic               pop;

  assign valid_o = (count_q != 2'd0);
  assign head_o  = ent_q[0];
  assign pop     = valid_o && ready_i;
  assign free_o  = 2'd2 - count_q + {1'b0, pop};

  always_comb begin
    ent_d[0] = ent_q[0];
    ent_d[1] = ent_q[1];
    cnt      = count_q;
    if (pop) begin
      ent_d[0] = ent_q[1];
      cnt      = count_q - 2'd1;
    end
    if (push_n_i != 2'd0) begin
      ent_d[cnt[0]] = res0_i;
    end
    if (push_n_i == 2'd2) begin
      ent_d[1] = res1_i;
    end
    count_d = cnt + push_n_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q[0] <= ent_d[0];
    ent_q[1] <= ent_d[1];
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("result buffer count out of range");

  a_push_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_n_i <= free_o)
    else $error("push overflows result buffer");

  // A replacement that is not last always has its ASCII word behind it.
  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && ready_i && head_o.is_replacement && !head_o.last |=> valid_o)
    else $error("replacement word lost its partner");
`endif

endmodule

>>> design/utf8d_byte_stream_decoder_core.sv
// Top level of the UTF-8 byte stream decoder: input register, decode step,
// result buffer. Uses utf8d_pkg, utf8d_if, utf8d_step, utf8d_result_fifo.
//
//   channel   dir  payload                               role
//   byte_i    in   byte_in[7:0]                          raw UTF-8 stream
//   cp_o      out  code_point[20:0], is_replacement, last decoded characters
//
// One byte per cycle while its words fit; both byte and words are registered.
// An ASCII byte that closes an open sequence gives two words; the buffer
// takes both, and a byte waits in the input register while its words do not fit.
// Reset clears the pending count, partial code point, input valid and buffer count.
// Output stalls back up through the two-word buffer, then the input register.
module utf8_byte_stream_decoder_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  utf8d_byte_if.sink   byte_i,
  utf8d_cp_if.source   cp_o
);

  logic               in_valid_q;
  logic [7:0]         byte_q;
  logic               fire;
  logic [1:0]         free;
  utf8d_pkg::step_t   step;
  utf8d_pkg::result_t head;

  assign fire         = in_valid_q && (step.n <= free);
  assign byte_i.ready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (byte_i.valid && byte_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      byte_q <= byte_i.byte_in;
    end
  end

  utf8d_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_q),
    .fire_i (fire),
    .step_o (step)
  );

  utf8d_result_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (fire ? step.n : 2'd0),
    .res0_i   (step.res0),
    .res1_i   (step.res1),
    .free_o   (free),
    .valid_o  (cp_o.valid),
    .ready_i  (cp_o.ready),
    .head_o   (head)
  );

  assign cp_o.code_point     = head.code_point;
  assign cp_o.is_replacement = head.is_replacement;
  assign cp_o.last           = head.last;

`ifndef SYNTHESIS
  // A held byte is consumed as soon as the buffer has room for its words.
  a_no_stall_when_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && free == 2'd2 |-> fire)
    else $error("input held although result buffer is empty");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> byte_i.ready)
    else $error("input not ready with empty input register");

  a_repl_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cp_o.valid && cp_o.is_replacement |-> cp_o.code_point == utf8d_pkg::REPLACEMENT_CP)
    else $error("replacement word with wrong code point");
`endif

endmodule

>>> verif/utf8d_decode_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the UTF-8 byte stream decoder: predicts the code point words
// of every accepted byte and compares the output words in order.
// Depends on utf8d_pkg and the channel interfaces in utf8d_if.
module utf8d_decode_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  utf8d_byte_if byte_mon,
  utf8d_cp_if   cp_mon,
  output int    mismatch_count_o,
  output int    words_open_o,
  output int    words_checked_o,
  output int    repl_checked_o
);

  localparam int MaxReports = 10;
  localparam int unsigned CpW = utf8d_pkg::CpW;

  logic [CpW-1:0]     cp_partial = '0;
  logic [1:0]         cont_due = '0;
  utf8d_pkg::result_t cp_expect_q[$];
  int                 n_fail = 0;
  int                 n_checked = 0;
  int                 n_repl = 0;

  // Advance the predicted decoder state by one byte, queue the words it emits.
  task automatic decode_byte(input logic [7:0] b);
    utf8d_pkg::kind_e kind;
    casez (b)
      8'b0???_????: kind = utf8d_pkg::KIND_ASCII;
      8'b10??_????: kind = utf8d_pkg::KIND_CONT;
      8'b110?_????: kind = utf8d_pkg::KIND_LEAD2;
      8'b1110_????: kind = utf8d_pkg::KIND_LEAD3;
      8'b1111_0???: kind = utf8d_pkg::KIND_LEAD4;
      default:      kind = utf8d_pkg::KIND_BAD;
    endcase
    case (kind)
      utf8d_pkg::KIND_BAD: ;
      utf8d_pkg::KIND_CONT: begin
        // stray continuation is dropped
        if (cont_due != 2'd0) begin
          cont_due = cont_due - 2'd1;
          cp_partial = cp_partial | (CpW'(b[5:0]) << (6 * cont_due));
          if (cont_due == 2'd0) begin
            cp_expect_q.push_back(utf8d_pkg::result_t'{code_point: cp_partial,
                                                       is_replacement: 1'b0,
                                                       last: 1'b1});
          end
        end
      end
      default: begin
        // open sequence cut short: replacement word first
        if (cont_due != 2'd0) begin
          cp_expect_q.push_back(utf8d_pkg::result_t'{code_point: utf8d_pkg::REPLACEMENT_CP,
                                                     is_replacement: 1'b1,
                                                     last: (kind != utf8d_pkg::KIND_ASCII)});
        end
        case (kind)
          utf8d_pkg::KIND_ASCII: begin
            cont_due = 2'd0;
            cp_expect_q.push_back(utf8d_pkg::result_t'{code_point: CpW'(b[6:0]),
                                                       is_replacement: 1'b0,
                                                       last: 1'b1});
          end
          utf8d_pkg::KIND_LEAD2: begin
            cont_due = 2'd1;
            cp_partial = CpW'(b[4:0]) << 6;
          end
          utf8d_pkg::KIND_LEAD3: begin
            cont_due = 2'd2;
            cp_partial = CpW'(b[3:0]) << 12;
          end
          utf8d_pkg::KIND_LEAD4: begin
            cont_due = 2'd3;
            cp_partial = CpW'(b[2:0]) << 18;
          end
          default: ;
        endcase
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    utf8d_pkg::result_t want;
    utf8d_pkg::result_t got;
    if (!rst_ni) begin
      cp_partial = '0;
      cont_due = '0;
      cp_expect_q.delete();
      mismatch_count_o <= n_fail;
      words_open_o <= 0;
    end else begin
      if (byte_mon.valid && byte_mon.ready) begin
        decode_byte(byte_mon.byte_in);
      end
      if (cp_mon.valid && cp_mon.ready) begin
        got = utf8d_pkg::result_t'{code_point: cp_mon.code_point,
                                   is_replacement: cp_mon.is_replacement,
                                   last: cp_mon.last};
        if (cp_expect_q.size() == 0) begin
          if (n_fail < MaxReports) begin
            $display("unexpected word: cp %06h repl %b last %b",
                     got.code_point, got.is_replacement, got.last);
          end
          n_fail++;
        end else begin
          want = cp_expect_q.pop_front();
          if (got.code_point !== want.code_point ||
              got.is_replacement !== want.is_replacement ||
              got.last !== want.last) begin
            if (n_fail < MaxReports) begin
              $display("word mismatch: exp cp %06h repl %b last %b, got cp %06h repl %b last %b",
                       want.code_point, want.is_replacement, want.last,
                       got.code_point, got.is_replacement, got.last);
            end
            n_fail++;
          end
          n_checked++;
          if (want.is_replacement) n_repl++;
        end
      end
      mismatch_count_o <= n_fail;
      words_open_o <= cp_expect_q.size();
      words_checked_o <= n_checked;
      repl_checked_o <= n_repl;
    end
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Top of the UTF-8 decoder testbench: clock, reset, byte stimulus, output
// back-pressure and verdict. Uses utf8d_pkg, utf8d_if and utf8d_decode_checker.
module testbench;

  localparam int NumRandomBytes = 1850;
  localparam int NumDirected = 28;
  localparam int CycleLimit = 500000;
  localparam int DrainCycles = 8;
  localparam int MaxGap = 6;

  logic clk_i;
  logic rst_ni;
  int   mismatch_count;
  int   words_open;
  int   words_checked;
  int   repl_checked;
  int   cycle_count = 0;
  int   bytes_sent = 0;
  bit   no_idle = 1'b0;

  // extremes, every byte class, and the drop / interrupt cases
  logic [7:0] directed_seq [NumDirected] = '{
    8'h00, 8'h7F, 8'hF8, 8'hFF,            // ASCII ends, invalid bytes
    8'hC2, 8'hA9,                          // 2-byte
    8'hE2, 8'h82, 8'hAC,                   // 3-byte
    8'hF0, 8'h9F, 8'h98, 8'h80,            // 4-byte
    8'hF7, 8'hBF, 8'hBF, 8'hBF,            // largest 21-bit value
    8'hBF,                                 // stray continuation
    8'hC3, 8'hE2, 8'h82, 8'hAC,            // cut short by a lead
    8'hE2, 8'h82, 8'h41,                   // cut short by ASCII
    8'hC3, 8'hFF, 8'hA9                    // invalid byte inside a sequence
  };

  utf8d_byte_if byte_ch ();
  utf8d_cp_if   cp_ch ();

  utf8_byte_stream_decoder_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_ch),
    .cp_o   (cp_ch)
  );

  utf8d_decode_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .byte_mon         (byte_ch),
    .cp_mon           (cp_ch),
    .mismatch_count_o (mismatch_count),
    .words_open_o     (words_open),
    .words_checked_o  (words_checked),
    .repl_checked_o   (repl_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Output side: random stall before each word, none while no_idle is set.
  initial begin
    int stall;
    cp_ch.ready = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MaxGap);
      if (stall > 0) begin
        cp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      cp_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!cp_ch.valid);
    end
  end

  // valid stays high when the next byte follows without a gap
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.byte_in <= b;
    do @(posedge clk_i); while (!byte_ch.ready);
    bytes_sent++;
  endtask

  task automatic drain_words();
    byte_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (words_open != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] lead_byte(input int n_cont);
    logic [7:0] b;
    case (n_cont)
      1:       b = 8'hC0 | 8'($urandom_range(0, 31));
      2:       b = 8'hE0 | 8'($urandom_range(0, 15));
      default: b = 8'hF0 | 8'($urandom_range(0, 7));
    endcase
    return b;
  endfunction

  // Mostly well-formed characters, some noise bytes and cut-short sequences.
  task automatic send_random_sequence();
    int pick;
    int n_cont;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      send_byte(8'($urandom_range(0, 127)));
    end else if (pick < 85) begin
      n_cont = (pick < 55) ? 1 : (pick < 70) ? 2 : 3;
      send_byte(lead_byte(n_cont));
      repeat (n_cont) send_byte(8'h80 | 8'($urandom_range(0, 63)));
    end else if (pick < 93) begin
      send_byte(8'($urandom_range(0, 255)));
    end else begin
      n_cont = $urandom_range(1, 3);
      send_byte(lead_byte(n_cont));
      repeat ($urandom_range(0, n_cont - 1)) send_byte(8'h80 | 8'($urandom_range(0, 63)));
    end
  endtask

  initial begin
    bit paused_mid;
    paused_mid = 1'b0;
    rst_ni = 1'b0;
    byte_ch.valid = 1'b0;
    byte_ch.byte_in = 8'h00;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (directed_seq[i]) send_byte(directed_seq[i]);
    drain_words();

    while (bytes_sent < NumDirected + NumRandomBytes) begin
      if ($urandom_range(0, 15) == 0) no_idle = !no_idle;
      // hold off once mid-run until every pending word has come out
      if (!paused_mid && bytes_sent >= NumDirected + NumRandomBytes / 2) begin
        drain_words();
        paused_mid = 1'b1;
      end
      send_random_sequence();
    end

    drain_words();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d bytes: directed classes and cut-short cases, then random streams",
             bytes_sent);
    $display("with and without idle gaps; checked %0d words, %0d replacements.",
             words_checked, repl_checked);
    if (mismatch_count == 0 && words_open == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
design/utf8d_pkg.sv
design/utf8d_if.sv
design/utf8d_step.sv
design/utf8d_result_fifo.sv
design/utf8d_byte_stream_decoder_core.sv
verif/utf8d_decode_checker.sv
verif/testbench.sv
